### rtl/spgf_pkg.sv
// Package: shared constants and payload types for the stacked point ground filter.
`default_nettype none
package spgf_pkg;
  localparam int MaxPoints  = 64;
  localparam int CoordWidth = 32;
  localparam int EffWidth   = (CoordWidth < 32) ? CoordWidth : 32;
  localparam int IdxWidth   = $clog2(MaxPoints);
  localparam int CntWidth   = $clog2(MaxPoints + 1);

  localparam logic [1:0] ClassNonGround = 2'd0;
  localparam logic [1:0] ClassDuplicate = 2'd1;
  localparam logic [1:0] ClassNone      = 2'd2;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic               batch_end;
  } point_in_t;

  typedef struct packed {
    logic [5:0] point_index;
    logic [1:0] class_code;
    logic       dropped_flag;
    logic       final_result;
  } result_out_t;

  // Control and shifted data passed from one cell to the next.
  typedef struct packed {
    logic                       load;    // write point into the first free cell
    logic                       probe;   // compare probe against held points
    logic signed [EffWidth-1:0] x;
    logic signed [EffWidth-1:0] y;
    logic signed [EffWidth-1:0] z;
  } spgf_bus_t;

  // Keep the effective low bits of a coordinate as a signed value.
  function automatic logic signed [EffWidth-1:0] coord_trim(input logic [31:0] v);
    coord_trim = v[EffWidth-1:0];
  endfunction
endpackage
`default_nettype wire

### rtl/stacked_point_ground_filter_unit.sv
// Top level: point loading, cell chain and result sequencing.
//  channel | ports                       | handshake
//  input   | start, busy, point_in       | transfer when start && !busy
//  result  | result_valid, result        | one result per cycle, no stall
// Loading takes one point per cycle while busy is low. On a closing item every
// stored point is streamed down the chain once and the probes drain out, then
// n results leave one per cycle; busy is high throughout.
// Reset clears the cells and the counters; the receiver cannot stall.
`default_nettype none
module stacked_point_ground_filter_unit (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire spgf_pkg::point_in_t   point_in,
  output logic                       result_valid,
  output spgf_pkg::result_out_t      result
);
  import spgf_pkg::*;

  typedef enum logic [1:0] {S_LOAD, S_PROBE, S_DRAIN, S_EMIT} state_t;
  state_t state;

  logic [CntWidth-1:0] count, step;
  logic                overflow, clear;
  logic signed [EffWidth-1:0] mx [MaxPoints];
  logic signed [EffWidth-1:0] my [MaxPoints];
  logic signed [EffWidth-1:0] mz [MaxPoints];
  logic signed [EffWidth-1:0] rx, ry, rz;
  spgf_bus_t bus [MaxPoints+1];
  logic [MaxPoints-1:0] filled;
  logic [1:0] cls [MaxPoints];
  logic accept;
  logic full;

  assign accept = start && !busy;
  assign busy   = (state != S_LOAD);
  assign full   = (count == CntWidth'(MaxPoints));
  // Empty the cells at the edge that sends the last result.
  assign clear  = (state == S_EMIT) && (step + 1'b1 == count);

  // Point memory replays the batch as probes.
  always_ff @(posedge clk) begin
    if (accept && !full) begin
      mx[count[IdxWidth-1:0]] <= coord_trim(point_in.px);
      my[count[IdxWidth-1:0]] <= coord_trim(point_in.py);
      mz[count[IdxWidth-1:0]] <= coord_trim(point_in.pz);
    end
    rx <= mx[step[IdxWidth-1:0]];
    ry <= my[step[IdxWidth-1:0]];
    rz <= mz[step[IdxWidth-1:0]];
  end

  logic probe_d;
  always_comb begin
    bus[0].load  = accept && !full;
    bus[0].probe = probe_d;
    bus[0].x = (state == S_LOAD) ? coord_trim(point_in.px) : rx;
    bus[0].y = (state == S_LOAD) ? coord_trim(point_in.py) : ry;
    bus[0].z = (state == S_LOAD) ? coord_trim(point_in.pz) : rz;
  end

  // Build the chain of cells.
  for (genvar i = 0; i < MaxPoints; i++) begin : g_cell
    spgf_cell u_cell (
      .clk(clk), .rst(rst), .clear(clear),
      .fill_prev((i == 0) ? 1'b1 : filled[(i == 0) ? 0 : i-1]),
      .bus_in(bus[i]), .bus_out(bus[i+1]),
      .filled(filled[i]), .cls(cls[i])
    );
  end

  // Sequence load, probe, drain and emit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD; count <= '0; overflow <= 1'b0; step <= '0;
      probe_d <= 1'b0; result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_LOAD: begin
          probe_d <= 1'b0;
          if (accept) begin
            if (full) overflow <= 1'b1;
            else      count <= count + 1'b1;
            if (point_in.batch_end) begin
              state <= S_PROBE; step <= '0;
            end
          end
        end
        S_PROBE: begin
          probe_d <= 1'b1;
          if (step + 1'b1 == count) begin
            state <= S_DRAIN; step <= '0;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_DRAIN: begin
          probe_d <= 1'b0;
          if (step == CntWidth'(MaxPoints)) begin
            state <= S_EMIT; step <= '0;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_EMIT: begin
          result_valid <= 1'b1;
          result.point_index  <= 6'(step[IdxWidth-1:0]);
          result.class_code   <= cls[step[IdxWidth-1:0]];
          result.dropped_flag <= overflow;
          result.final_result <= (step + 1'b1 == count);
          if (step + 1'b1 == count) begin
            state <= S_LOAD; count <= '0; overflow <= 1'b0;
          end else begin
            step <= step + 1'b1;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/spgf_cell.sv
// Cell: holds one point and its running group minimum and duplicate count.
`default_nettype none
module spgf_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              clear,
  input  wire logic              fill_prev,  // all cells before this one are filled
  input  wire spgf_pkg::spgf_bus_t bus_in,
  output spgf_pkg::spgf_bus_t    bus_out,
  output logic                   filled,
  output logic [1:0]             cls
);
  import spgf_pkg::*;

  logic signed [EffWidth-1:0] hx, hy, hz, low;
  logic [1:0] low_cnt;  // saturating count of group points at low
  logic same, hit_lo, hit_eq;
  logic take;

  assign same   = (bus_in.x == hx) && (bus_in.y == hy);
  assign hit_lo = same && (bus_in.z < low);
  assign hit_eq = same && (bus_in.z == low);
  assign take   = bus_in.load && fill_prev && !filled;

  // Hold point; track group minimum as every probe streams past.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      filled <= 1'b0;
    end else if (take) begin
      filled <= 1'b1;
    end
    if (take) begin
      hx <= bus_in.x; hy <= bus_in.y; hz <= bus_in.z; low <= bus_in.z;
      low_cnt <= 2'd0;
    end else if (bus_in.probe && filled) begin
      if (hit_lo) begin
        low <= bus_in.z; low_cnt <= 2'd1;
      end else if (hit_eq && low_cnt != 2'd2) begin
        low_cnt <= low_cnt + 2'd1;
      end
    end
  end

  // Pass the stream on to the neighbour; a load taken here goes no further.
  always_ff @(posedge clk) begin
    if (rst) begin
      bus_out.load <= 1'b0; bus_out.probe <= 1'b0;
    end else begin
      bus_out.load <= bus_in.load && !take; bus_out.probe <= bus_in.probe;
    end
    bus_out.x <= bus_in.x; bus_out.y <= bus_in.y; bus_out.z <= bus_in.z;
  end

  always_comb begin
    if (hz > low)             cls = ClassNonGround;
    else if (low_cnt == 2'd2) cls = ClassDuplicate;
    else                      cls = ClassNone;
  end
endmodule
`default_nettype wire
